FILE: rtl/screened_coulomb_polynomial_macros.svh
// ----------------------------------------------------------------------------
// screened_coulomb_polynomial assertion macros
// Shared property shorthands for the screened Coulomb kernel.
// ----------------------------------------------------------------------------
`ifndef SCREENED_COULOMB_POLYNOMIAL_MACROS_SVH
`define SCREENED_COULOMB_POLYNOMIAL_MACROS_SVH

// same-cycle implication, disabled in reset
`define SCP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// fixed-delay implication, disabled in reset
`define SCP_ASSERT_DELAY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

FILE: rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Widths, coefficients and shared types of the screened Coulomb kernel.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int DIST_W    = 20;            // Q4.16
  localparam int PROD_W    = 2 * DIST_W;    // Q8.32
  localparam int X_W       = 30;            // scaled distance, Q.28, below 3.5
  localparam int X_SHIFT   = 4;             // Q.32 -> Q.28
  localparam int ACC_W     = 42;            // signed Q.28 accumulator
  localparam int MAG_W     = ACC_W - 1;
  localparam int LO_W      = 21;
  localparam int HI_W      = MAG_W - LO_W;
  localparam int PP_W      = MAG_W + X_W;
  localparam int FRAC_P    = 28;
  localparam int NUM_COEF  = 11;
  localparam int NUM_STEPS = NUM_COEF - 1;
  localparam int OUT_W     = 33;            // Q17.16
  localparam int NUM_W     = MAG_W + 4;     // poly << 4
  localparam int TOP_W     = NUM_W - OUT_W;

  localparam logic [PROD_W-1:0] CUTOFF_P = 40'h03_8000_0000;  // 3.5 in Q8.32
  localparam logic [OUT_W-1:0]  OUT_MAX  = {OUT_W{1'b1}};
  localparam logic [DIST_W-1:0] ALPHA_RESET = 20'h1_0000;

  // Horner coefficients in Q.28, c0 first
  localparam logic signed [ACC_W-1:0] COEF [NUM_COEF] = '{
    42'sd268463583, -42'sd303993239, 42'sd10449544, 42'sd58451239,
    42'sd91066404, -42'sd142871953, 42'sd81910635, -42'sd25287965,
    42'sd4442765, -42'sd415590, 42'sd15848
  };

  typedef struct packed {
    logic valid;
    logic cut;   // beyond cutoff
    logic ovf;   // quotient overflow or zero distance
  } scp_ctl_t;

endpackage

FILE: rtl/scp_horner_step.sv
// ----------------------------------------------------------------------------
// scp_horner_step
// One Horner step acc' = c + round(acc * x), split over two register stages.
// ----------------------------------------------------------------------------
module scp_horner_step import scp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  scp_ctl_t                ctl_i,
  input  logic [DIST_W-1:0]       dist_i,
  input  logic [X_W-1:0]          x_i,
  input  logic signed [ACC_W-1:0] acc_i,
  input  logic signed [ACC_W-1:0] coef_i,
  output scp_ctl_t                ctl_o,
  output logic [DIST_W-1:0]       dist_o,
  output logic [X_W-1:0]          x_o,
  output logic signed [ACC_W-1:0] acc_o
);

  scp_ctl_t              ctl_a_r, ctl_b_r;
  logic [DIST_W-1:0]     dist_a_r, dist_b_r;
  logic [X_W-1:0]        x_a_r, x_b_r;
  logic                  neg_a_r;
  logic [LO_W+X_W-1:0]   pp_lo_r, pp_lo_nxt;
  logic [HI_W+X_W-1:0]   pp_hi_r, pp_hi_nxt;
  logic signed [ACC_W-1:0] acc_b_r, acc_b_nxt;
  logic [MAG_W-1:0]      mag;
  logic [PP_W-1:0]       prod;
  logic [ACC_W-1:0]      rnd;
  logic signed [ACC_W-1:0] term;

  // stage A: magnitude times x, as two partial products
  always_comb begin
    mag       = acc_i[ACC_W-1] ? MAG_W'(-acc_i) : acc_i[MAG_W-1:0];
    pp_lo_nxt = {{X_W{1'b0}}, mag[LO_W-1:0]} * {{LO_W{1'b0}}, x_i};
    pp_hi_nxt = {{X_W{1'b0}}, mag[MAG_W-1:LO_W]} * {{HI_W{1'b0}}, x_i};
  end

  // stage B: combine, round half away from zero, add coefficient
  always_comb begin
    prod      = {pp_hi_r, {LO_W{1'b0}}} + {{HI_W{1'b0}}, pp_lo_r};
    prod      = prod + (PP_W'(1) << (FRAC_P - 1));
    rnd       = ACC_W'(prod >> FRAC_P);
    term      = neg_a_r ? -$signed(rnd) : $signed(rnd);
    acc_b_nxt = coef_i + term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    dist_a_r <= dist_i;
    x_a_r    <= x_i;
    neg_a_r  <= acc_i[ACC_W-1];
    pp_lo_r  <= pp_lo_nxt;
    pp_hi_r  <= pp_hi_nxt;
    dist_b_r <= dist_a_r;
    x_b_r    <= x_a_r;
    acc_b_r  <= acc_b_nxt;
  end

  assign ctl_o  = ctl_b_r;
  assign dist_o = dist_b_r;
  assign x_o    = x_b_r;
  assign acc_o  = acc_b_r;

endmodule

FILE: rtl/scp_div_stage.sv
// ----------------------------------------------------------------------------
// scp_div_stage
// One restoring division step: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module scp_div_stage import scp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  scp_ctl_t          ctl_i,
  input  logic [DIST_W-1:0] dist_i,
  input  logic [DIST_W-1:0] rem_i,
  input  logic [OUT_W-1:0]  num_i,
  input  logic [OUT_W-1:0]  quo_i,
  output scp_ctl_t          ctl_o,
  output logic [DIST_W-1:0] dist_o,
  output logic [DIST_W-1:0] rem_o,
  output logic [OUT_W-1:0]  num_o,
  output logic [OUT_W-1:0]  quo_o
);

  scp_ctl_t          ctl_r;
  logic [DIST_W-1:0] dist_r, rem_r, rem_nxt;
  logic [OUT_W-1:0]  num_r, quo_r;
  logic [DIST_W:0]   trial, diff;
  logic              ge;

  always_comb begin
    trial   = {rem_i, num_i[OUT_W-1]};
    diff    = trial - {1'b0, dist_i};
    ge      = trial >= {1'b0, dist_i};
    rem_nxt = ge ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_i;
    rem_r  <= rem_nxt;
    num_r  <= {num_i[OUT_W-2:0], 1'b0};
    quo_r  <= {quo_i[OUT_W-2:0], ge};
  end

  assign ctl_o  = ctl_r;
  assign dist_o = dist_r;
  assign rem_o  = rem_r;
  assign num_o  = num_r;
  assign quo_o  = quo_r;

endmodule

FILE: rtl/screened_coulomb_polynomial.sv
// ----------------------------------------------------------------------------
// screened_coulomb_polynomial
// Pipelined erfc(alpha*r)/r estimate: Q4.16 distance in, Q17.16 value out.
// ----------------------------------------------------------------------------
// Takes one distance request on every clock (busy is always low) and returns
// one result per request, in order: out_strobe is high for a single cycle per
// result and the receiver cannot hold it off. The pipeline holds the input
// register, the alpha*r multiply, ten Horner steps of two stages each
// (partial products, then round and add), a clamp stage, 33 restoring divide
// stages (one quotient bit each) and the output register.
// Beyond alpha*r >= 3.5 the result is zero; zero distance or quotient overflow
// gives all ones with out_saturated set. Write cfg_wdata (alpha, Q4.16) only
// while no request is in flight; reset value of alpha is 1.0.
module screened_coulomb_polynomial import scp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [DIST_W-1:0] in_distance,
  input  logic              cfg_we,
  input  logic [DIST_W-1:0] cfg_wdata,
  output logic              out_strobe,
  output logic [OUT_W-1:0]  out_screened_value,
  output logic              out_saturated
);

  `include "screened_coulomb_polynomial_macros.svh"

  localparam int DIV_STAGES = OUT_W;
  localparam int PIPE_DEPTH = 4 + 2 * NUM_STEPS + DIV_STAGES;

  logic              in_accept;
  logic [DIST_W-1:0] alpha_r;

  // stage 0: request capture
  logic              v0_r;
  logic [DIST_W-1:0] dist0_r;
  // stage 1: scaled distance product
  logic              v1_r;
  logic [DIST_W-1:0] dist1_r;
  logic [PROD_W-1:0] prod1_r;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        alpha_r <= cfg_wdata;
      end
      v0_r <= in_accept;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    dist0_r <= in_distance;
    dist1_r <= dist0_r;
    prod1_r <= {{DIST_W{1'b0}}, dist0_r} * {{DIST_W{1'b0}}, alpha_r};
  end

  // Horner chain, highest coefficient first
  scp_ctl_t                ctl_h  [NUM_STEPS+1];
  logic [DIST_W-1:0]       dist_h [NUM_STEPS+1];
  logic [X_W-1:0]          x_h    [NUM_STEPS+1];
  logic signed [ACC_W-1:0] acc_h  [NUM_STEPS+1];

  always_comb begin
    ctl_h[0].valid = v1_r;
    ctl_h[0].cut   = prod1_r >= CUTOFF_P;
    ctl_h[0].ovf   = 1'b0;
  end
  assign dist_h[0] = dist1_r;
  assign x_h[0]    = prod1_r[X_SHIFT+X_W-1:X_SHIFT];  // Q.32 -> Q.28, truncated
  assign acc_h[0]  = COEF[NUM_COEF-1];

  for (genvar g = 0; g < NUM_STEPS; g++) begin : g_horner
    scp_horner_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl_h[g]),
      .dist_i (dist_h[g]),
      .x_i    (x_h[g]),
      .acc_i  (acc_h[g]),
      .coef_i (COEF[NUM_COEF-2-g]),
      .ctl_o  (ctl_h[g+1]),
      .dist_o (dist_h[g+1]),
      .x_o    (x_h[g+1]),
      .acc_o  (acc_h[g+1])
    );
  end

  // clamp stage: negative poly -> 0, numerator poly << 4, overflow check
  scp_ctl_t          ctl_c_r, ctl_c_nxt;
  logic [DIST_W-1:0] dist_c_r, rem_c_nxt, rem_c_r;
  logic [OUT_W-1:0]  num_c_r;
  logic [MAG_W-1:0]  poly;
  logic [NUM_W-1:0]  num_full;

  always_comb begin
    poly      = acc_h[NUM_STEPS][ACC_W-1] ? '0 : acc_h[NUM_STEPS][MAG_W-1:0];
    num_full  = {poly, 4'b0000};
    rem_c_nxt = {{(DIST_W-TOP_W){1'b0}}, num_full[NUM_W-1:OUT_W]};
    ctl_c_nxt = ctl_h[NUM_STEPS];
    // quotient >= 2^33 exactly when the top bits already reach the divisor;
    // this also catches zero distance
    ctl_c_nxt.ovf = rem_c_nxt >= dist_h[NUM_STEPS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c_r <= '0;
    end else begin
      ctl_c_r <= ctl_c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_c_r <= dist_h[NUM_STEPS];
    rem_c_r  <= rem_c_nxt;
    num_c_r  <= num_full[OUT_W-1:0];
  end

  // divider chain
  scp_ctl_t          ctl_d  [DIV_STAGES+1];
  logic [DIST_W-1:0] dist_d [DIV_STAGES+1];
  logic [DIST_W-1:0] rem_d  [DIV_STAGES+1];
  logic [OUT_W-1:0]  num_d  [DIV_STAGES+1];
  logic [OUT_W-1:0]  quo_d  [DIV_STAGES+1];

  assign ctl_d[0]  = ctl_c_r;
  assign dist_d[0] = dist_c_r;
  assign rem_d[0]  = rem_c_r;
  assign num_d[0]  = num_c_r;
  assign quo_d[0]  = '0;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    scp_div_stage u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl_d[g]),
      .dist_i (dist_d[g]),
      .rem_i  (rem_d[g]),
      .num_i  (num_d[g]),
      .quo_i  (quo_d[g]),
      .ctl_o  (ctl_d[g+1]),
      .dist_o (dist_d[g+1]),
      .rem_o  (rem_d[g+1]),
      .num_o  (num_d[g+1]),
      .quo_o  (quo_d[g+1])
    );
  end

  // output register
  scp_ctl_t         ctl_f;
  logic             strobe_r;
  logic [OUT_W-1:0] value_r, value_nxt;
  logic             sat_r, sat_nxt;

  always_comb begin
    ctl_f     = ctl_d[DIV_STAGES];
    sat_nxt   = !ctl_f.cut && ctl_f.ovf;
    value_nxt = ctl_f.cut ? '0 : (ctl_f.ovf ? OUT_MAX : quo_d[DIV_STAGES]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl_f.valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    sat_r   <= sat_nxt;
  end

  assign out_strobe         = strobe_r;
  assign out_screened_value = value_r;
  assign out_saturated      = sat_r;

  // checks
  `SCP_ASSERT_IMPL(a_sat_is_max, out_strobe && out_saturated, out_screened_value == OUT_MAX, "saturated result not all ones")
  `SCP_ASSERT_DELAY(a_latency, in_accept, PIPE_DEPTH, out_strobe, "request lost in pipeline")
  `SCP_ASSERT_NEXT(a_alpha_hold, !cfg_we, $stable(alpha_r), "alpha changed without a write")

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the screened Coulomb kernel: every distance request is predicted
// in fixed point and the results are compared in order, across alpha
// settings and idle patterns.
// ----------------------------------------------------------------------------

// Scoreboard: holds alpha, predicts one result per request, checks in order.
class coulomb_scoreboard;
  typedef struct {
    logic [32:0] value;
    logic        sat;
  } coulomb_result_t;

  logic [19:0]     alpha;
  coulomb_result_t pending[$];
  int              errors;
  int              checked;
  int              sat_seen;
  int              zero_seen;

  // polynomial coefficients times 2^32, c0 first
  longint coef_q32[11] = '{
    64'sd4295417332, -64'sd4863891829, 64'sd167192710, 64'sd935219817,
    64'sd1457062459, -64'sd2285951252, 64'sd1310570156, -64'sd404607446,
    64'sd71084232, -64'sd6649435, 64'sd253566
  };

  function new();
    alpha = 20'h1_0000;
    errors = 0;
    checked = 0;
    sat_seen = 0;
    zero_seen = 0;
  endfunction

  // Q.32 -> Q.28, rounded half away from zero
  function longint coef_q28(int k);
    longint c;
    longint m;
    c = coef_q32[k];
    m = (c < 0) ? -c : c;
    m = (m + 8) >>> 4;
    return (c < 0) ? -m : m;
  endfunction

  function coulomb_result_t screened_estimate(logic [19:0] d);
    coulomb_result_t r;
    logic [63:0]  p;
    logic [63:0]  x;
    logic [127:0] prod;
    logic [127:0] mag;
    logic [127:0] num;
    logic [127:0] q;
    longint       acc;
    longint       m;
    longint       limit;
    r.value = '0;
    r.sat = 1'b0;
    limit = 64'sd1 <<< 61;
    p = 64'(d) * 64'(alpha);
    if (p >= (64'd7 << 31)) return r;            // beyond cutoff
    if (d == 0) begin                             // zero distance
      r.value = '1;
      r.sat = 1'b1;
      return r;
    end
    x = p >> 4;
    acc = coef_q28(10);
    for (int k = 9; k >= 0; k--) begin
      m = (acc < 0) ? -acc : acc;
      prod = 128'(m) * 128'(x) + (128'd1 << 27);
      mag = prod >> 28;
      if (mag > 128'(limit)) mag = 128'(limit);
      acc = coef_q28(k) + ((acc < 0) ? -longint'(mag[63:0]) : longint'(mag[63:0]));
      if (acc > limit) acc = limit;
      if (acc < -limit) acc = -limit;
    end
    if (acc < 0) acc = 0;                         // negative polynomial clamps
    if (acc >= (64'sd1 <<< 60)) begin
      r.value = '1;
      r.sat = 1'b1;
      return r;
    end
    num = 128'(acc) << 4;
    q = num / 128'(d);
    if (q > 128'h1_FFFF_FFFF) begin
      r.value = '1;
      r.sat = 1'b1;
    end else begin
      r.value = q[32:0];
    end
    return r;
  endfunction

  function void note_request(logic [19:0] d);
    pending.push_back(screened_estimate(d));
  endfunction

  function void check_result(logic [32:0] value, logic sat);
    coulomb_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result value=%0h sat=%0b", $time, value, sat);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (sat) sat_seen++;
    if (value == 0) zero_seen++;
    if (value !== e.value) begin
      $display("%0t: screened_value expected %0h actual %0h", $time, e.value, value);
      errors++;
    end
    if (sat !== e.sat) begin
      $display("%0t: saturated expected %0b actual %0b", $time, e.sat, sat);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import scp_pkg::*;

  localparam int  LATENCY     = 60;
  localparam int  CYCLE_LIMIT = 300000;
  localparam int  PER_PHASE   = 225;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [DIST_W-1:0] in_distance;
  logic              cfg_we;
  logic [DIST_W-1:0] cfg_wdata;
  logic              out_strobe;
  logic [OUT_W-1:0]  out_screened_value;
  logic              out_saturated;

  coulomb_scoreboard sb;
  int                cycles;
  int                sender_idle;   // percent of requests followed by an idle gap
  int                requests;

  screened_coulomb_polynomial dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_distance(in_distance), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_screened_value(out_screened_value),
    .out_saturated(out_saturated)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Monitor: inputs are driven by NBA at the edge, so values seen here are the
  // ones the block samples at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.alpha = cfg_wdata;
      if (start && !busy) begin
        sb.note_request(in_distance);
        requests++;
      end
      if (out_strobe) sb.check_result(out_screened_value, out_saturated);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, sb.pending.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // One request; start stays high so back-to-back requests need no re-raise.
  task automatic send_distance(logic [DIST_W-1:0] d);
    bit took;
    start <= 1'b1;
    in_distance <= d;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
    if ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      in_distance <= 20'($urandom);
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // Let the pipeline empty out before touching alpha.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_alpha(logic [DIST_W-1:0] a);
    cfg_we <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random distances, weighted toward the range below cutoff.
  task automatic random_distances(int n);
    longint lim;
    int     sel;
    longint d;
    longint edge_d;
    for (int i = 0; i < n; i++) begin
      lim = (sb.alpha == 0) ? 64'hFFFFF : ((64'd7 << 31) - 1) / sb.alpha;
      if (lim > 64'hFFFFF) lim = 64'hFFFFF;
      edge_d = lim;
      sel = $urandom_range(99);
      if (sel < 60) d = (lim < 1) ? 0 : $urandom_range(int'(lim), 1);
      else if (sel < 75) d = $urandom_range(20'hFFFFF);
      else if (sel < 85) d = $urandom_range(16);
      else begin
        d = edge_d + $urandom_range(8) - 4;
        if (d < 0) d = 0;
        if (d > 64'hFFFFF) d = 64'hFFFFF;
      end
      send_distance(d[19:0]);
    end
  endtask

  initial begin
    logic [DIST_W-1:0] alphas[6];
    int                idle_pattern[4];
    sb = new();
    cycles = 0;
    requests = 0;
    sender_idle = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_distance = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset alpha of 1.0; zero distance, tiny distances, the cutoff
    // edge at 3.5, the region just below it where the polynomial dips
    // negative, and the top of the range.
    foreach (alphas[i]) alphas[i] = '0;
    send_distance(20'd0);
    send_distance(20'd1);
    send_distance(20'd2);
    send_distance(20'd3);
    send_distance(20'd16);
    send_distance(20'h1_0000);
    send_distance(20'd229370);
    send_distance(20'd229374);
    send_distance(20'd229375);
    send_distance(20'd229376);
    send_distance(20'd229377);
    send_distance(20'd200000);
    send_distance(20'h5_5555);
    send_distance(20'hA_AAAA);
    send_distance(20'hF_FFFE);
    send_distance(20'hF_FFFF);
    send_distance(20'h0_8000);

    // alpha settings: reset, zero, max, one LSB, 2.0, random
    alphas = '{20'h1_0000, 20'h0_0000, 20'hF_FFFF, 20'h0_0001, 20'h2_0000,
               20'($urandom)};
    idle_pattern = '{0, 64, 0, 25};
    foreach (alphas[i]) begin
      drain();
      write_alpha(alphas[i]);
      // alpha of zero: all requests see x = 0, so only small distances matter
      foreach (idle_pattern[j]) begin
        sender_idle = idle_pattern[j];
        random_distances(PER_PHASE / 4);
      end
    end

    drain();
    $display("Covered %0d requests over %0d alpha settings; %0d saturated, %0d zero results.",
             requests, 6, sb.sat_seen, sb.zero_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
